[src/rv32i_instruction_decoder_macros.svh]
// assertion helpers for the decoder top level
`ifndef RV32I_INSTRUCTION_DECODER_MACROS_SVH
`define RV32I_INSTRUCTION_DECODER_MACROS_SVH

// same-cycle implication, quiet during reset
`define RVD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define RVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rvd_pkg.sv]
package rvd_pkg;

    localparam logic [31:0] HALT_WORD = 32'h0FF0_0513;

    // major opcodes
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SL  = 3'd1;
    localparam logic [2:0] F3_SR  = 3'd5;

    // operation numbers
    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_SUB   = 6'd1;
    localparam logic [5:0] OP_SLL   = 6'd2;
    localparam logic [5:0] OP_SLT   = 6'd3;
    localparam logic [5:0] OP_SLTU  = 6'd4;
    localparam logic [5:0] OP_XOR   = 6'd5;
    localparam logic [5:0] OP_SRL   = 6'd6;
    localparam logic [5:0] OP_SRA   = 6'd7;
    localparam logic [5:0] OP_OR    = 6'd8;
    localparam logic [5:0] OP_AND   = 6'd9;
    localparam logic [5:0] OP_ADDI  = 6'd10;
    localparam logic [5:0] OP_SLTI  = 6'd11;
    localparam logic [5:0] OP_SLTIU = 6'd12;
    localparam logic [5:0] OP_XORI  = 6'd13;
    localparam logic [5:0] OP_ORI   = 6'd14;
    localparam logic [5:0] OP_ANDI  = 6'd15;
    localparam logic [5:0] OP_SLLI  = 6'd16;
    localparam logic [5:0] OP_SRLI  = 6'd17;
    localparam logic [5:0] OP_SRAI  = 6'd18;
    localparam logic [5:0] OP_LB    = 6'd19;
    localparam logic [5:0] OP_LH    = 6'd20;
    localparam logic [5:0] OP_LW    = 6'd21;
    localparam logic [5:0] OP_LBU   = 6'd22;
    localparam logic [5:0] OP_LHU   = 6'd23;
    localparam logic [5:0] OP_SB    = 6'd24;
    localparam logic [5:0] OP_SH    = 6'd25;
    localparam logic [5:0] OP_SW    = 6'd26;
    localparam logic [5:0] OP_BEQ   = 6'd27;
    localparam logic [5:0] OP_BNE   = 6'd28;
    localparam logic [5:0] OP_BLT   = 6'd29;
    localparam logic [5:0] OP_BGE   = 6'd30;
    localparam logic [5:0] OP_BLTU  = 6'd31;
    localparam logic [5:0] OP_BGEU  = 6'd32;
    localparam logic [5:0] OP_LUI   = 6'd33;
    localparam logic [5:0] OP_AUIPC = 6'd34;
    localparam logic [5:0] OP_JAL   = 6'd35;
    localparam logic [5:0] OP_JALR  = 6'd36;
    localparam logic [5:0] OP_HALT  = 6'd37;
    // marks an unused funct3 slot in the tables below
    localparam logic [5:0] OP_NONE  = 6'd63;

    // lookup by funct3
    localparam logic [5:0] R_OPS [8] = '{
        OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_OR, OP_AND
    };
    localparam logic [5:0] OPIMM_OPS [8] = '{
        OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_SRLI, OP_ORI, OP_ANDI
    };
    localparam logic [5:0] LOAD_OPS [8] = '{
        OP_LB, OP_LH, OP_LW, OP_NONE, OP_LBU, OP_LHU, OP_NONE, OP_NONE
    };
    localparam logic [5:0] STORE_OPS [8] = '{
        OP_SB, OP_SH, OP_SW, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE
    };
    localparam logic [5:0] BRANCH_OPS [8] = '{
        OP_BEQ, OP_BNE, OP_NONE, OP_NONE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU
    };

    typedef struct packed {
        logic [31:0] instruction_word;
    } t_request;

    typedef struct packed {
        logic [5:0]  operation;
        logic        illegal;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [31:0] immediate;
    } t_result;

endpackage

[src/rvd_stream_if.sv]
interface rvd_stream_if #(
    parameter type T = logic [31:0]
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/rvd_decode.sv]
module rvd_decode
    import rvd_pkg::*;
(
    input  logic [31:0] i_word,
    output t_result     o_result
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [5:0]  op;
    t_result     dec;

    assign opc = i_word[6:0];
    assign rd  = i_word[11:7];
    assign f3  = i_word[14:12];
    assign rs1 = i_word[19:15];
    assign rs2 = i_word[24:20];
    assign f7  = i_word[31:25];

    assign imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                    i_word[11:8], 1'b0};
    assign imm_u = {i_word[31:12], 12'b0};
    assign imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                    i_word[30:21], 1'b0};

    always_comb begin
        op  = OP_NONE;
        dec = '0;
        if (i_word == HALT_WORD) begin
            op = OP_HALT;
        end else begin
            case (opc)
                OPC_OP: begin
                    if (f7 == F7_BASE) begin
                        op = R_OPS[f3];
                    end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                        op = OP_SUB;
                    end else if (f7 == F7_ALT && f3 == F3_SR) begin
                        op = OP_SRA;
                    end
                    dec.dest_reg = rd;
                    dec.src1_reg = rs1;
                    dec.src2_reg = rs2;
                end
                OPC_OP_IMM: begin
                    if (f3 == F3_SL || f3 == F3_SR) begin
                        // shift amount sits in the rs2 slot
                        if (f7 == F7_BASE) begin
                            op = OPIMM_OPS[f3];
                        end else if (f7 == F7_ALT && f3 == F3_SR) begin
                            op = OP_SRAI;
                        end
                        dec.immediate = {27'b0, rs2};
                    end else begin
                        op = OPIMM_OPS[f3];
                        dec.immediate = imm_i;
                    end
                    dec.dest_reg = rd;
                    dec.src1_reg = rs1;
                end
                OPC_LOAD: begin
                    op = LOAD_OPS[f3];
                    dec.dest_reg  = rd;
                    dec.src1_reg  = rs1;
                    dec.immediate = imm_i;
                end
                OPC_STORE: begin
                    op = STORE_OPS[f3];
                    dec.src1_reg  = rs1;
                    dec.src2_reg  = rs2;
                    dec.immediate = imm_s;
                end
                OPC_BRANCH: begin
                    op = BRANCH_OPS[f3];
                    dec.src1_reg  = rs1;
                    dec.src2_reg  = rs2;
                    dec.immediate = imm_b;
                end
                OPC_LUI: begin
                    op = OP_LUI;
                    dec.dest_reg  = rd;
                    dec.immediate = imm_u;
                end
                OPC_AUIPC: begin
                    op = OP_AUIPC;
                    dec.dest_reg  = rd;
                    dec.immediate = imm_u;
                end
                OPC_JAL: begin
                    op = OP_JAL;
                    dec.dest_reg  = rd;
                    dec.immediate = imm_j;
                end
                OPC_JALR: begin
                    if (f3 == F3_ADD) begin
                        op = OP_JALR;
                    end
                    dec.dest_reg  = rd;
                    dec.src1_reg  = rs1;
                    dec.immediate = imm_i;
                end
                default: begin
                    op = OP_NONE;
                end
            endcase
        end

        if (op == OP_NONE) begin
            o_result         = '0;
            o_result.illegal = 1'b1;
        end else begin
            o_result           = dec;
            o_result.operation = op;
            o_result.illegal   = 1'b0;
        end
    end

endmodule

[src/rv32i_instruction_decoder.sv]
// flow: a word accepted into the word register moves on to the result register once that register can load
// throughput: one word per cycle, limited only by the result register being taken
// decode is one combinational pass between the word register and the result register
// reset clears both stage valid flags; payload registers are not reset
`include "rv32i_instruction_decoder_macros.svh"
module rv32i_instruction_decoder
    import rvd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rvd_stream_if.sink   i_instr,
    rvd_stream_if.source o_result
);

    logic        r_s1_valid;
    logic        n_s1_valid;
    logic [31:0] r_word;
    logic        r_out_valid;
    logic        n_out_valid;
    t_result     r_out;
    t_result     dec_result;
    logic        out_free;
    logic        in_take;
    logic        s1_move;

    rvd_decode u_decode (
        .i_word   (r_word),
        .o_result (dec_result)
    );

    // result register can load when empty or being drained this cycle
    assign out_free = !r_out_valid || o_result.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign i_instr.ready = !r_s1_valid || out_free;
    assign in_take  = i_instr.valid && i_instr.ready;

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (i_instr.ready) begin
            n_s1_valid = i_instr.valid;
        end
        if (out_free) begin
            n_out_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_word <= i_instr.data.instruction_word;
        end
        if (s1_move) begin
            r_out <= dec_result;
        end
    end

    `RVD_ASSERT_NEXT(a_stage_advance, i_clk, i_rst_n, s1_move, r_out_valid,
        "word stage moved but result register is empty")
    `RVD_ASSERT_NOW(a_illegal_zero, i_clk, i_rst_n, r_out_valid && r_out.illegal,
        r_out.operation == '0 && r_out.dest_reg == '0 && r_out.src1_reg == '0 &&
        r_out.src2_reg == '0 && r_out.immediate == '0,
        "illegal result carries nonzero fields")
    `RVD_ASSERT_NOW(a_op_range, i_clk, i_rst_n, r_out_valid,
        r_out.operation <= OP_HALT, "operation number out of range")
    `RVD_ASSERT_NOW(a_halt_clean, i_clk, i_rst_n,
        r_out_valid && r_out.operation == OP_HALT,
        !r_out.illegal && r_out.dest_reg == '0 && r_out.src1_reg == '0 &&
        r_out.src2_reg == '0 && r_out.immediate == '0,
        "halt result carries nonzero fields")

endmodule
